### hdl/etcc_pkg.sv
package etcc_pkg;

    localparam int SAMPLE_W = 8;
    localparam int INDEX_W  = 32;
    localparam int PIN_W    = 3;
    localparam int OUT_TDATA_W = 48;

    // Configuration register indexes
    localparam logic [1:0] REG_WATCH_MASK  = 2'd0;
    localparam logic [1:0] REG_TRIG_MODE   = 2'd1;
    localparam logic [1:0] REG_TRIG_PIN    = 2'd2;
    localparam logic [1:0] REG_LAST_INDEX  = 2'd3;

    localparam logic [SAMPLE_W-1:0] WATCH_MASK_RST = 8'hFF;
    localparam logic [INDEX_W-1:0]  LAST_INDEX_RST = 32'd1000000;

    // Trigger modes; the unused code behaves as no trigger
    localparam logic [1:0] TRIG_NONE = 2'd0;
    localparam logic [1:0] TRIG_FALL = 2'd1;
    localparam logic [1:0] TRIG_RISE = 2'd2;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_CAPTURE = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] watch_mask;
        logic [1:0]          trigger_mode;
        logic [PIN_W-1:0]    trigger_pin;
        logic [INDEX_W-1:0]  last_sample_index;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic                trig_primed;
        logic                cap_primed;
        logic [SAMPLE_W-1:0] prev_sample;
        logic [INDEX_W-1:0]  count;
    } state_t;

    typedef struct packed {
        logic                any_high;
        logic [SAMPLE_W-1:0] pins_value;
        logic [INDEX_W-1:0]  sample_index;
    } result_t;

endpackage

### hdl/etcc_step.sv
module etcc_step (
    input  logic [etcc_pkg::SAMPLE_W-1:0] sample,
    input  etcc_pkg::cfg_t                cfg,
    input  etcc_pkg::state_t              cur,
    output etcc_pkg::state_t              nxt,
    output logic                          res_valid,
    output etcc_pkg::result_t             res
);
    import etcc_pkg::*;

    logic                trig_on;
    logic                bit_prev;
    logic                bit_now;
    logic                fired;
    logic                enter;
    logic                active;
    logic                primed_eff;
    logic [INDEX_W-1:0]  count_eff;
    logic [SAMPLE_W-1:0] masked;

    always_comb
    begin
        trig_on  = (cfg.trigger_mode == TRIG_FALL) || (cfg.trigger_mode == TRIG_RISE);
        bit_prev = cur.prev_sample[cfg.trigger_pin];
        bit_now  = sample[cfg.trigger_pin];
        fired    = (cfg.trigger_mode == TRIG_FALL) ? (bit_prev && !bit_now)
                                                   : (!bit_prev && bit_now);
        // The very first sample under a trigger only primes the edge detector.
        enter      = (cur.phase == PH_WAIT) && (!trig_on || (cur.trig_primed && fired));
        active     = (cur.phase == PH_CAPTURE) || enter;
        primed_eff = enter ? 1'b0 : cur.cap_primed;
        count_eff  = enter ? '0 : cur.count;
    end

    // Next state
    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_WAIT:
            begin
                if (!enter)
                begin
                    nxt.trig_primed = 1'b1;
                    nxt.prev_sample = sample;
                end
            end
            PH_CAPTURE, PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase
        if (active)
        begin
            nxt.cap_primed  = 1'b1;
            nxt.prev_sample = sample;
            if (count_eff >= cfg.last_sample_index)
            begin
                nxt.phase = PH_DONE;
                nxt.count = count_eff;
            end
            else
            begin
                nxt.phase = PH_CAPTURE;
                nxt.count = INDEX_W'(count_eff + 32'd1);
            end
        end
    end

    // Result
    always_comb
    begin
        masked           = sample & cfg.watch_mask;
        res_valid        = active &&
                           (!primed_eff || ((cur.prev_sample & cfg.watch_mask) != masked));
        res.sample_index = count_eff;
        res.pins_value   = masked;
        res.any_high     = |masked;
    end

endmodule

### hdl/edge_triggered_change_capture.sv
// Channel | Direction | tdata fields (low bit up)                       | tuser/tlast
// s_*     | in        | pin_sample[7:0]                                 | none
// m_*     | out       | sample_index[31:0], pins_value[39:32],          | none
//         |           | any_high[40], zero [47:41]                      |
// One item per cycle unless a held result stalls; a result shows the next cycle.
// The output register holds a result until taken, and a new item is accepted in
// the same cycle that the held result leaves.
// Reset (rst_n low, asynchronous) restores register defaults and the waiting phase.
// A stall on the output side stops input acceptance only while a result is held.
module edge_triggered_change_capture (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wen,
    input  logic [1:0]                         cfg_addr,
    input  logic [etcc_pkg::INDEX_W-1:0]       cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [etcc_pkg::SAMPLE_W-1:0]      s_tdata,   // pin_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [etcc_pkg::OUT_TDATA_W-1:0]   m_tdata    // sample_index, pins_value, any_high
);
    import etcc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    res_valid;
    result_t res;
    result_t res_reg;
    logic    m_tvalid_reg;
    logic    s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    etcc_step u_step (
        .sample    (s_tdata),
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.watch_mask        <= WATCH_MASK_RST;
            cfg_reg.trigger_mode      <= TRIG_NONE;
            cfg_reg.trigger_pin       <= '0;
            cfg_reg.last_sample_index <= LAST_INDEX_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                REG_WATCH_MASK: cfg_reg.watch_mask        <= cfg_wdata[SAMPLE_W-1:0];
                REG_TRIG_MODE:  cfg_reg.trigger_mode      <= cfg_wdata[1:0];
                REG_TRIG_PIN:   cfg_reg.trigger_pin       <= cfg_wdata[PIN_W-1:0];
                REG_LAST_INDEX: cfg_reg.last_sample_index <= cfg_wdata;
                default:        cfg_reg.last_sample_index <= cfg_reg.last_sample_index;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_WAIT;
            state_reg.trig_primed <= 1'b0;
            state_reg.cap_primed  <= 1'b0;
            state_reg.prev_sample <= '0;
            state_reg.count       <= '0;
            m_tvalid_reg          <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - INDEX_W - SAMPLE_W - 1){1'b0}}, res_reg};

`ifndef ASSERT_OFF
    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_DONE |=> state_reg.phase == PH_DONE)
        else $error("capture left the done phase");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_DONE) && !m_tvalid_reg |=> !m_tvalid_reg)
        else $error("result produced after capture finished");

    a_capture_primed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_CAPTURE |-> state_reg.cap_primed)
        else $error("capturing without a previous sample");

    a_start_reported: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (state_reg.phase == PH_WAIT) && (state_next.phase != PH_WAIT)
        |=> m_tvalid_reg && (res_reg.sample_index == '0))
        else $error("capture start not reported as index zero");
`endif

endmodule
